>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL. All use clk and the active-low rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when cond holds, expect must hold too.
`define AST_IMPLY(lbl, cond, expect_c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_c)) \
    else $error(msg);

// Next-cycle implication: when cond holds, expect must hold in the next cycle.
`define AST_NEXT(lbl, cond, expect_c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_c)) \
    else $error(msg);

`endif

>>> sv/epd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_pkg
// Shared constants and types of the ping zero-run decoder.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int MAX_SAMPLES = 4096;

  localparam int AMP_W   = 27;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int BYTE_W  = 8;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MANT_W  = 12;
  localparam int EXP_W   = 4;

  localparam logic [BYTE_W-1:0] RUN_MARK = 8'hFF;
  localparam logic [LEN_W-1:0]  MAX_SAMPLES_C = LEN_W'(MAX_SAMPLES);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BEAM_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_PING = 2'd1;

  // beam modes
  localparam logic [MODE_W-1:0] BEAM_SINGLE = 2'd0;
  localparam logic [MODE_W-1:0] BEAM_DUAL   = 2'd1;
  localparam logic [MODE_W-1:0] BEAM_SPLIT  = 2'd2;

  // input commands
  localparam logic CMD_CHUNK = 1'b0;
  localparam logic CMD_END   = 1'b1;

  // run bookkeeping for the item in the input register
  typedef struct packed {
    logic               emit;   // item produces a result
    logic               zero;   // result carries zero sample values
    logic               last;   // end-of-ping fill
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } run_info_t;

endpackage

>>> sv/epd_word_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_word_dec
// Decode a 16-bit exponent/mantissa word into an integer amplitude.
// ----------------------------------------------------------------------------
module epd_word_dec (
  input  logic [epd_pkg::BYTE_W-1:0] lo_byte,
  input  logic [epd_pkg::BYTE_W-1:0] hi_byte,
  output logic [epd_pkg::AMP_W-1:0]  value
);
  import epd_pkg::*;

  logic [MANT_W-1:0] mant;
  logic [EXP_W-1:0]  expo;
  logic [AMP_W-1:0]  norm;

  assign mant = {hi_byte[3:0], lo_byte};
  assign expo = hi_byte[7:4];
  // hidden leading one above the mantissa
  assign norm = {{(AMP_W-MANT_W-1){1'b0}}, 1'b1, mant};

  always_comb begin
    if (expo == '0) begin
      value = {{(AMP_W-MANT_W){1'b0}}, mant};
    end else begin
      value = norm << (expo - EXP_W'(1));
    end
  end

endmodule

>>> sv/epd_run_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_run_ctrl
// Sample counter of the current ping and run start/length for each item.
// ----------------------------------------------------------------------------
module epd_run_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [epd_pkg::LEN_W-1:0]    samples_per_ping,
  input  logic                         cmd,
  input  logic [epd_pkg::BYTE_W-1:0]   first_byte,
  input  logic [epd_pkg::BYTE_W-1:0]   second_byte,
  input  logic                         advance,
  output epd_pkg::run_info_t           info
);
  import epd_pkg::*;

  logic [LEN_W-1:0] sample_count_r;
  logic [LEN_W-1:0] sample_count_nxt;
  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] room;
  logic [LEN_W-1:0] run_n;
  logic             is_run;

  // clamp the ping length into 1..MAX_SAMPLES
  always_comb begin
    if (samples_per_ping == '0) begin
      limit = LEN_W'(1);
    end else if (samples_per_ping > MAX_SAMPLES_C) begin
      limit = MAX_SAMPLES_C;
    end else begin
      limit = samples_per_ping;
    end
  end

  assign room   = (sample_count_r < limit) ? (limit - sample_count_r) : '0;
  assign is_run = (second_byte == RUN_MARK);
  assign run_n  = {{(LEN_W-BYTE_W){1'b0}}, first_byte} + LEN_W'(2);

  always_comb begin
    info.last  = (cmd == CMD_END);
    info.emit  = (cmd == CMD_END) || (room != '0);
    info.zero  = (cmd == CMD_END) || is_run;
    info.start = sample_count_r[START_W-1:0];
    if (cmd == CMD_END) begin
      info.len = room;
      if (room == '0) begin
        info.start = '0;
      end
    end else if (is_run) begin
      info.len = (run_n > room) ? room : run_n;
    end else begin
      info.len = LEN_W'(1);
    end
  end

  always_comb begin
    sample_count_nxt = sample_count_r;
    if (advance) begin
      if (cmd == CMD_END) begin
        sample_count_nxt = '0;
      end else if (room != '0) begin
        sample_count_nxt = sample_count_r + info.len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
    end else begin
      sample_count_r <= sample_count_nxt;
    end
  end

endmodule

>>> sv/echo_ping_rle_float_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_ping_rle_float_decoder
// Zero-run expansion and float decode of compressed echosounder ping chunks.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one compressed chunk or an end-of-ping
// command. A chunk is captured in an input register, decoded and run-counted
// in combinational logic, and lands in the result register; the block takes a
// new chunk every cycle unless in_stall holds it off, and each result passes
// the input register, then the result register. A chunk whose second byte is
// 0xFF yields one result for a zero run of first_byte + 2 samples, cut to
// the room left in the ping; any other chunk yields one decoded sample.
// Chunks that arrive after the ping is full are dropped without a result.
// The end-of-ping command always yields one result with last_of_ping set,
// carrying the zero fill up to samples_per_ping, and restarts the count.
// samples_per_ping of 0 acts as 1 and values above 4096 act as 4096; beam_mode
// 3 acts as single-beam. Write configuration only while no item is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module echo_ping_rle_float_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [epd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [epd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [epd_pkg::BYTE_W-1:0]        in_first_byte,
  input  logic [epd_pkg::BYTE_W-1:0]        in_second_byte,
  input  logic [epd_pkg::BYTE_W-1:0]        in_third_byte,
  input  logic [epd_pkg::BYTE_W-1:0]        in_fourth_byte,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [epd_pkg::AMP_W-1:0]         out_amplitude,
  output logic [epd_pkg::AMP_W-1:0]         out_second_value,
  output logic [epd_pkg::BYTE_W-1:0]        out_third_value,
  output logic [epd_pkg::START_W-1:0]       out_run_start,
  output logic [epd_pkg::LEN_W-1:0]         out_run_length,
  output logic                              out_last_of_ping
);
  import epd_pkg::*;

  // configuration registers
  logic [MODE_W-1:0] beam_mode_r;
  logic [LEN_W-1:0]  samples_per_ping_r;

  // input register
  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic [BYTE_W-1:0] s1_b1_r;
  logic [BYTE_W-1:0] s1_b2_r;
  logic [BYTE_W-1:0] s1_b3_r;
  logic [BYTE_W-1:0] s1_b4_r;

  // result register
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [AMP_W-1:0]   amp_r;
  logic [AMP_W-1:0]   v2_r;
  logic [BYTE_W-1:0]  v3_r;
  logic [START_W-1:0] start_r;
  logic [LEN_W-1:0]   len_r;
  logic               last_r;

  // decode path
  run_info_t         info;
  logic [AMP_W-1:0]  narrow_val;
  logic [AMP_W-1:0]  wide_val;
  logic [AMP_W-1:0]  amp_nxt;
  logic [AMP_W-1:0]  v2_nxt;
  logic [BYTE_W-1:0] v3_nxt;
  logic              out_free;
  logic              s1_go;
  logic              load_out;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_mode_r        <= BEAM_SINGLE;
      samples_per_ping_r <= LEN_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BEAM_MODE:        beam_mode_r        <= cfg_wdata[MODE_W-1:0];
        REG_SAMPLES_PER_PING: samples_per_ping_r <= cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  // An item with no result leaves the input register without waiting.
  assign s1_go    = s1_valid_r && (out_free || !info.emit);
  assign load_out = s1_go && info.emit;
  assign in_stall = s1_valid_r && !s1_go;

  // Input register: advance on each accepted transfer, drop on empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r <= in_cmd;
      s1_b1_r  <= in_first_byte;
      s1_b2_r  <= in_second_byte;
      s1_b3_r  <= in_third_byte;
      s1_b4_r  <= in_fourth_byte;
    end
  end

  epd_run_ctrl u_run_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .samples_per_ping (samples_per_ping_r),
    .cmd              (s1_cmd_r),
    .first_byte       (s1_b1_r),
    .second_byte      (s1_b2_r),
    .advance          (s1_go),
    .info             (info)
  );

  epd_word_dec u_narrow_dec (
    .lo_byte (s1_b1_r),
    .hi_byte (s1_b2_r),
    .value   (narrow_val)
  );

  epd_word_dec u_wide_dec (
    .lo_byte (s1_b3_r),
    .hi_byte (s1_b4_r),
    .value   (wide_val)
  );

  // Select the per-mode values; zero runs and the fill carry zeros.
  always_comb begin
    amp_nxt = narrow_val;
    v2_nxt  = '0;
    v3_nxt  = '0;
    case (beam_mode_r)
      BEAM_DUAL: begin
        v2_nxt = wide_val;
      end
      BEAM_SPLIT: begin
        v2_nxt = {{(AMP_W-BYTE_W){1'b0}}, s1_b3_r};
        v3_nxt = s1_b4_r;
      end
      default: begin
      end
    endcase
    if (info.zero) begin
      amp_nxt = '0;
      v2_nxt  = '0;
      v3_nxt  = '0;
    end
  end

  // Result register: load a new result, clear on transfer, else hold.
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      amp_r   <= amp_nxt;
      v2_r    <= v2_nxt;
      v3_r    <= v3_nxt;
      start_r <= info.start;
      len_r   <= info.len;
      last_r  <= info.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_amplitude    = amp_r;
  assign out_second_value = v2_r;
  assign out_third_value  = v3_r;
  assign out_run_start    = start_r;
  assign out_run_length   = len_r;
  assign out_last_of_ping = last_r;

  // An empty input register never holds off the source.
  `AST_IMPLY(a_no_stall_empty, !s1_valid_r, !in_stall, "input stalled while empty")
  // A result leaving the input register shows up in the result register.
  `AST_NEXT(a_load_shows, load_out, out_valid_r, "loaded result not valid")
  // Only the end-of-ping fill may have zero length.
  `AST_IMPLY(a_len_nonzero, out_valid_r && !last_r, len_r != '0, "sample result of zero length")
  // The fill carries zero values, and an empty fill starts at zero.
  `AST_IMPLY(a_fill_zero, out_valid_r && last_r,
             amp_r == '0 && v2_r == '0 && v3_r == '0 && (len_r != '0 || start_r == '0),
             "end-of-ping fill carries data")

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ping zero-run decoder.
// ----------------------------------------------------------------------------
// A queue of chunks and end-of-ping commands feeds a clocked driver. A clocked
// monitor mirrors every accepted transfer in a bit-exact run predictor that
// keeps its own copy of the configuration and of the sample count. Each result
// transfer is checked field by field against the oldest predicted run. The run
// starts with directed chunks (decode extremes, run cutting, full pings, the
// beam modes and odd ping lengths). Random pings follow under several register
// settings and idle mixes, including a long output hold-off that backs the
// block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import epd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 8;      // lets dropped chunks still in the pipe pass
  localparam logic [MODE_W-1:0] BEAM_ALIAS = 2'd3;  // undefined mode, acts single

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic [BYTE_W-1:0] b4;
  } chunk_t;

  typedef struct packed {
    logic [AMP_W-1:0]   amp;
    logic [AMP_W-1:0]   v2;
    logic [BYTE_W-1:0]  v3;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               last;
  } run_t;

  // DUT signals; every input starts at a known value
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_cmd = 1'b0;
  logic [BYTE_W-1:0]     in_first_byte = '0;
  logic [BYTE_W-1:0]     in_second_byte = '0;
  logic [BYTE_W-1:0]     in_third_byte = '0;
  logic [BYTE_W-1:0]     in_fourth_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [AMP_W-1:0]      out_amplitude;
  logic [AMP_W-1:0]      out_second_value;
  logic [BYTE_W-1:0]     out_third_value;
  logic [START_W-1:0]    out_run_start;
  logic [LEN_W-1:0]      out_run_length;
  logic                  out_last_of_ping;

  // stimulus and scoreboard state
  chunk_t chunk_backlog[$];
  run_t   pending_runs[$];
  chunk_t next_chunk;
  int     chunks_queued = 0;
  int     chunks_taken = 0;
  int     mismatches = 0;
  int     cycles = 0;
  int     send_idle_pct = 33;
  int     recv_idle_pct = 52;
  int     hold_requests = 0;
  int     hold_served = 0;
  int     hold_left = 0;
  logic   in_took = 1'b0;

  // predictor copy of the block's registers and ping position
  logic [MODE_W-1:0] beam;
  logic [LEN_W-1:0]  ping_len;
  logic [LEN_W-1:0]  ping_fill;

  echo_ping_rle_float_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_first_byte   (in_first_byte),
    .in_second_byte  (in_second_byte),
    .in_third_byte   (in_third_byte),
    .in_fourth_byte  (in_fourth_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_amplitude   (out_amplitude),
    .out_second_value(out_second_value),
    .out_third_value (out_third_value),
    .out_run_start   (out_run_start),
    .out_run_length  (out_run_length),
    .out_last_of_ping(out_last_of_ping)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 4-bit exponent over 12-bit mantissa; exponent 0 keeps the mantissa as is
  function automatic logic [AMP_W-1:0] float_word(input logic [BYTE_W-1:0] lo,
                                                  input logic [BYTE_W-1:0] hi);
    logic [15:0]      word;
    logic [AMP_W-1:0] mant;
    word = {hi, lo};
    mant = AMP_W'(word[MANT_W-1:0]);
    if (word[15:12] == '0) return mant;
    return (mant + AMP_W'(16'h1000)) << (word[15:12] - 4'd1);
  endfunction

  // Advance the ping position for one chunk; return 1 when it yields a run.
  function automatic bit decode_chunk(input chunk_t c, output run_t r);
    int lim;
    int room;
    int n;
    lim = (ping_len == '0) ? 1 : (int'(ping_len) > MAX_SAMPLES) ? MAX_SAMPLES : int'(ping_len);
    room = (int'(ping_fill) < lim) ? lim - int'(ping_fill) : 0;
    r = '0;
    if (c.cmd == CMD_END) begin
      // fill the rest of the ping with zeros and restart the count
      r.len   = LEN_W'(room);
      r.start = (room != 0) ? START_W'(ping_fill) : '0;
      r.last  = 1'b1;
      ping_fill = '0;
      return 1'b1;
    end
    if (room == 0) return 1'b0;  // ping full: drop the chunk
    r.start = START_W'(ping_fill);
    if (c.b2 == RUN_MARK) begin
      n = int'(c.b1) + 2;
      if (n > room) n = room;   // cut the run at the end of the ping
      r.len = LEN_W'(n);
      ping_fill = ping_fill + LEN_W'(n);
      return 1'b1;
    end
    r.amp = float_word(c.b1, c.b2);
    if (beam == BEAM_DUAL) begin
      r.v2 = float_word(c.b3, c.b4);
    end else if (beam == BEAM_SPLIT) begin
      r.v2 = AMP_W'(c.b3);
      r.v3 = c.b4;
    end
    r.len = LEN_W'(1);
    ping_fill = ping_fill + LEN_W'(1);
    return 1'b1;
  endfunction

  // Sender: hold a stalled transfer, otherwise offer the next chunk or idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the payload until it is taken
    end else if (chunk_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      next_chunk = chunk_backlog.pop_front();
      in_valid       <= 1'b1;
      in_cmd         <= next_chunk.cmd;
      in_first_byte  <= next_chunk.b1;
      in_second_byte <= next_chunk.b2;
      in_third_byte  <= next_chunk.b3;
      in_fourth_byte <= next_chunk.b4;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: a requested hold-off wins over random stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: mirror register writes, predict on input transfers, check results.
  always @(posedge clk) begin
    chunk_t seen;
    run_t   want;
    run_t   got;
    if (!rst_n) begin
      beam      = BEAM_SINGLE;
      ping_len  = LEN_W'(1024);
      ping_fill = '0;
      in_took  <= 1'b0;
      pending_runs.delete();
    end else begin
      in_took <= in_valid && !in_stall;
      if (cfg_we) begin
        if (cfg_index == REG_BEAM_MODE) beam = cfg_wdata[MODE_W-1:0];
        else if (cfg_index == REG_SAMPLES_PER_PING) ping_len = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        seen = '{in_cmd, in_first_byte, in_second_byte, in_third_byte, in_fourth_byte};
        chunks_taken++;
        if (decode_chunk(seen, want)) pending_runs.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{out_amplitude, out_second_value, out_third_value,
                out_run_start, out_run_length, out_last_of_ping};
        if (pending_runs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected run at cycle %0d: start %0d len %0d last %0b",
                     cycles, got.start, got.len, got.last);
        end else begin
          want = pending_runs.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: run mismatch at cycle %0d", cycles);
              $display("  expected amp %0d v2 %0d v3 %0d start %0d len %0d last %0b",
                       want.amp, want.v2, want.v3, want.start, want.len, want.last);
              $display("  actual   amp %0d v2 %0d v3 %0d start %0d len %0d last %0b",
                       got.amp, got.v2, got.v3, got.start, got.len, got.last);
            end
          end
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic push_chunk(input int b1, input int b2, input int b3, input int b4);
    chunk_backlog.push_back('{CMD_CHUNK, BYTE_W'(b1), BYTE_W'(b2), BYTE_W'(b3), BYTE_W'(b4)});
    chunks_queued++;
  endtask

  // end-of-ping ignores its bytes; drive them random anyway
  task automatic push_end();
    chunk_backlog.push_back('{CMD_END, BYTE_W'($urandom), BYTE_W'($urandom),
                              BYTE_W'($urandom), BYTE_W'($urandom)});
    chunks_queued++;
  endtask

  // Wait until every chunk is taken and every run has arrived, then let
  // dropped chunks still in the pipe pass before touching the registers.
  task automatic drain();
    @(negedge clk);
    while (chunks_taken != chunks_queued || pending_runs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // One ping: mostly samples and zero runs, a few stray end commands, and
  // sometimes no closing command at all.
  task automatic queue_ping(input int max_chunks);
    int n;
    int pick;
    n = $urandom_range(max_chunks, 0);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 25)
        push_chunk(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15),
                   RUN_MARK, $urandom, $urandom);
      else if (pick < 28)
        push_end();
      else
        push_chunk($urandom, $urandom, $urandom, $urandom);
    end
    if ($urandom_range(9) != 0) push_end();
  endtask

  task automatic random_phase(input logic [MODE_W-1:0] mode, input int spp,
                              input int n_items, input int max_chunks);
    int target;
    write_reg(REG_BEAM_MODE, int'(mode));
    write_reg(REG_SAMPLES_PER_PING, spp);
    target = chunks_queued + n_items;
    while (chunks_queued < target) queue_ping(max_chunks);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // decode extremes in single-beam mode; wide bytes must be ignored
    write_reg(REG_BEAM_MODE, int'(BEAM_SINGLE));
    write_reg(REG_SAMPLES_PER_PING, 1024);
    push_chunk(8'h00, 8'h00, 8'hFF, 8'hFF);
    push_chunk(8'hFF, 8'h0F, 8'hFF, 8'hFF);   // largest mantissa, exponent 0
    push_chunk(8'h00, 8'h10, 8'h00, 8'h00);   // exponent 1, mantissa 0
    push_chunk(8'hFF, 8'hFE, 8'h00, 8'h00);   // largest word that is not a run
    push_chunk(8'h00, RUN_MARK, 8'h00, 8'h00); // shortest zero run
    push_chunk(8'hFF, RUN_MARK, 8'hFF, 8'hFF); // longest zero run
    push_end();
    drain();

    // dual beam, tiny ping: run cut short, ping full, empty fill
    write_reg(REG_BEAM_MODE, int'(BEAM_DUAL));
    write_reg(REG_SAMPLES_PER_PING, 3);
    push_chunk(8'h34, 8'h12, 8'hFF, 8'hFE);
    push_chunk(8'h0A, RUN_MARK, 8'h00, 8'h00);
    push_chunk(8'h55, 8'h55, 8'h55, 8'h55);
    push_end();
    drain();

    // split beam with zero ping length, which acts as one sample
    write_reg(REG_BEAM_MODE, int'(BEAM_SPLIT));
    write_reg(REG_SAMPLES_PER_PING, 0);
    push_chunk(8'h01, 8'h80, 8'hAA, 8'h55);
    push_chunk(8'h02, 8'h03, 8'h55, 8'hAA);
    push_end();
    drain();

    // undefined mode acts single; oversized ping length clamps to the maximum
    write_reg(REG_BEAM_MODE, int'(BEAM_ALIAS));
    write_reg(REG_SAMPLES_PER_PING, 8191);
    push_chunk(8'h21, 8'h43, 8'h65, 8'h87);
    push_chunk(8'hFF, RUN_MARK, 8'h00, 8'h00);
    push_end();
    drain();

    // lower the ping length below the count already reached
    write_reg(REG_BEAM_MODE, int'(BEAM_SINGLE));
    write_reg(REG_SAMPLES_PER_PING, 10);
    for (int i = 0; i < 5; i++) push_chunk($urandom, $urandom_range(254), 0, 0);
    drain();
    write_reg(REG_SAMPLES_PER_PING, 2);
    push_chunk(8'h11, 8'h22, 8'h33, 8'h44);
    push_end();
    drain();

    // random pings: sender idles less than the receiver first
    random_phase(BEAM_SINGLE, 64, 100, 30);
    random_phase(BEAM_DUAL, MAX_SAMPLES, 100, 40);

    // then the other way round
    send_idle_pct = 52;
    recv_idle_pct = 33;
    random_phase(BEAM_SPLIT, 1, 100, 6);
    random_phase(BEAM_ALIAS, 8191, 100, 20);

    // no idling; open with a long output hold-off so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    random_phase(BEAM_DUAL, 200, 100, 30);

    if (mismatches == 0 && pending_runs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
